// ===== hw/rtl/per_peer_replay_window_dedup_macros.svh =====
// Assertion macros for the per-peer replay window filter.
// Included by per_peer_replay_window_dedup.sv, which checks its own logic; uses its clock and reset.
`ifndef PER_PEER_REPLAY_WINDOW_DEDUP_MACROS_SVH
`define PER_PEER_REPLAY_WINDOW_DEDUP_MACROS_SVH
`ifndef SYNTH
`define PPRWD_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define PPRWD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define PPRWD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PPRWD_ASSERT(lbl, cond, msg)
`define PPRWD_ASSERT_IMP(lbl, ante, cons, msg)
`define PPRWD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/pprwd_pkg.sv =====
// Shared sizes, types and codes of the per-peer replay window filter.
// No dependencies; used by pprwd_cell and per_peer_replay_window_dedup.
`default_nettype none

package pprwd_pkg;

   localparam int PEER_SLOTS   = 16;
   localparam int WINDOW_BITS  = 16;
   localparam int PEER_ID_BITS = 32;

   // The low ID_KEY_BITS bits (here all 32) of the 32-bit peer id port take part in the match.
   localparam int ID_KEY_BITS = (PEER_ID_BITS < 32) ? PEER_ID_BITS : 32;
   localparam int RANK_BITS   = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

   localparam logic CMD_CHECK = 1'b0;
   localparam logic CMD_STORE = 1'b1;

   localparam logic [7:0] STATUS_OK = 8'd0;

   typedef logic [ID_KEY_BITS-1:0] key_type;
   typedef logic [15:0]            seq_type;
   typedef logic [WINDOW_BITS-1:0] win_type;
   typedef logic [7:0]             status_type;
   typedef logic [RANK_BITS-1:0]   rank_type;
   typedef logic [PEER_SLOTS-1:0]  slot_vec_type;

   // What one cell shows to the controller.
   typedef struct packed {
      logic       valid;
      logic       hit;
      logic       first_free;
      logic       victim;
      seq_type    head_seq;
      win_type    window;
      status_type status;
      rank_type   rank;
   } cell_view_type;

   // Update broadcast from the controller to every cell.
   typedef struct packed {
      logic       en;
      logic       check;
      logic       fresh;
      rank_type   old_rank;
      logic       wr_seq;
      seq_type    seq;
      win_type    window;
      logic       wr_status;
      status_type status;
   } cell_upd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pprwd_cell.sv =====
// One peer slot of the replay filter: id, last sequence, window, status, LRU rank.
// Depends on pprwd_pkg; a row of these cells is built by per_peer_replay_window_dedup.
`default_nettype none

module pprwd_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pprwd_pkg::key_type     key,
   input  wire logic                   free_seen_in,
   output logic                        free_seen_out,
   input  wire logic                   sel,
   input  wire pprwd_pkg::cell_upd_type upd,
   output pprwd_pkg::cell_view_type    view
);

   logic                  valid_ff, valid_in;
   pprwd_pkg::rank_type   rank_ff, rank_in;
   pprwd_pkg::key_type    peer_ff, peer_in;
   pprwd_pkg::seq_type    head_seq_ff, head_seq_in;
   pprwd_pkg::win_type    window_ff, window_in;
   pprwd_pkg::status_type status_ff, status_in;

   // The free-slot token runs down the row: the first empty cell claims it.
   assign free_seen_out = free_seen_in | ~valid_ff;

   always_comb begin
      view.valid      = valid_ff;
      view.hit        = valid_ff && (peer_ff == key);
      view.first_free = ~valid_ff & ~free_seen_in;
      view.victim     = valid_ff &&
                        (rank_ff == pprwd_pkg::rank_type'(pprwd_pkg::PEER_SLOTS - 1));
      view.head_seq   = head_seq_ff;
      view.window     = window_ff;
      view.status     = status_ff;
      view.rank       = rank_ff;
   end

   always_comb begin
      valid_in    = valid_ff;
      rank_in     = rank_ff;
      peer_in     = peer_ff;
      head_seq_in = head_seq_ff;
      window_in   = window_ff;
      status_in   = status_ff;
      if (upd.en) begin
         if (sel) begin
            if (upd.check) begin
               valid_in  = 1'b1;
               rank_in   = '0;
               peer_in   = key;
               window_in = upd.window;
               if (upd.wr_seq) begin
                  head_seq_in = upd.seq;
               end
            end
            if (upd.wr_status) begin
               status_in = upd.status;
            end
         end else if (upd.check && valid_ff && (upd.fresh || rank_ff < upd.old_rank)) begin
            // Every peer younger than the touched one, or every valid peer when a new one is added, ages by one.
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      peer_ff     <= peer_in;
      head_seq_ff <= head_seq_in;
      window_ff   <= window_in;
      status_ff   <= status_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/per_peer_replay_window_dedup.sv =====
// Per-peer anti-replay filter: a row of peer cells and the lookup/update controller.
// Depends on pprwd_pkg, pprwd_cell and per_peer_replay_window_dedup_macros.svh.
`default_nettype none

// A word is taken when start is high and busy is low. Each word is first
// latched; then all peer cells compare the id at once and the free-slot token
// ripples down the row; then the window logic computes the new window and
// writes it into the chosen cell. rsp_valid is registered from that write and is
// a one-cycle result strobe that must be taken then; busy is already low in that
// cycle, so the next word can be issued while the result is shown, but not
// before. Check words that miss take the first empty slot, or else replace the
// least recently checked peer; store words to an unknown peer only return zeros.
`include "per_peer_replay_window_dedup_macros.svh"

module per_peer_replay_window_dedup (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_cmd,
   input  wire logic [31:0] req_peer_id,
   input  wire logic [15:0] req_seq_num,
   input  wire logic [7:0]  req_ack_status,
   output logic             rsp_valid,
   output logic             rsp_is_duplicate,
   output logic [7:0]       rsp_cached_status,
   output logic             rsp_new_peer,
   output logic             rsp_evicted
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_UPD  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Latched word.
   logic                  cmd_ff;
   pprwd_pkg::key_type    key_ff;
   pprwd_pkg::seq_type    seq_ff;
   pprwd_pkg::status_type ack_ff;

   // Lookup results.
   pprwd_pkg::slot_vec_type target_ff;
   logic                    hit_any_ff;
   logic                    evict_ff;
   pprwd_pkg::seq_type      last_ff;
   pprwd_pkg::win_type      win_ff;
   pprwd_pkg::status_type   status_ff;
   pprwd_pkg::rank_type     rank_ff;

   // Result registers.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  dup_ff, dup_in;
   pprwd_pkg::status_type cached_ff, cached_in;
   logic                  new_ff, new_in;
   logic                  ev_ff, ev_in;

   pprwd_pkg::cell_view_type view [pprwd_pkg::PEER_SLOTS];
   logic [pprwd_pkg::PEER_SLOTS:0] free_chain;
   pprwd_pkg::slot_vec_type        hit_vec, free_vec, victim_vec;
   logic                           any_free;
   pprwd_pkg::seq_type             g_last;
   pprwd_pkg::win_type             g_win;
   pprwd_pkg::status_type          g_status;
   pprwd_pkg::rank_type            g_rank;
   pprwd_pkg::cell_upd_type        upd;
   pprwd_pkg::seq_type             fwd_gap, back;
   pprwd_pkg::win_type             back_bit;

   assign free_chain[0] = 1'b0;
   assign any_free      = free_chain[pprwd_pkg::PEER_SLOTS];

   for (genvar i = 0; i < pprwd_pkg::PEER_SLOTS; i++) begin : g_cell
      pprwd_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .key           (key_ff),
         .free_seen_in  (free_chain[i]),
         .free_seen_out (free_chain[i+1]),
         .sel           (target_ff[i]),
         .upd           (upd),
         .view          (view[i])
      );
   end

   // At most one cell matches, so its fields are gathered by a masked OR.
   always_comb begin
      hit_vec    = '0;
      free_vec   = '0;
      victim_vec = '0;
      g_last     = '0;
      g_win      = '0;
      g_status   = '0;
      g_rank     = '0;
      for (int i = 0; i < pprwd_pkg::PEER_SLOTS; i++) begin
         hit_vec[i]    = view[i].hit;
         free_vec[i]   = view[i].first_free;
         victim_vec[i] = view[i].victim;
         if (view[i].hit) begin
            g_last   = g_last | view[i].head_seq;
            g_win    = g_win | view[i].window;
            g_status = g_status | view[i].status;
            g_rank   = g_rank | view[i].rank;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: state_in = ST_UPD;
         ST_UPD:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         cmd_ff <= req_cmd;
         key_ff <= req_peer_id[pprwd_pkg::ID_KEY_BITS-1:0];
         seq_ff <= req_seq_num;
         ack_ff <= req_ack_status;
      end
      if (state_ff == ST_LOOK) begin
         hit_any_ff <= |hit_vec;
         evict_ff   <= ~any_free;
         if (|hit_vec) begin
            target_ff <= hit_vec;
         end else if (any_free) begin
            target_ff <= free_vec;
         end else begin
            target_ff <= victim_vec;
         end
         last_ff   <= g_last;
         win_ff    <= g_win;
         status_ff <= g_status;
         rank_ff   <= g_rank;
      end
   end

   // Window update: signed 16-bit distance between the new and last numbers.
   assign fwd_gap  = seq_ff - last_ff;
   assign back     = 16'd0 - fwd_gap;
   assign back_bit = pprwd_pkg::win_type'(1) << back;

   always_comb begin
      upd           = '0;
      upd.en        = (state_ff == ST_UPD);
      upd.check     = (cmd_ff == pprwd_pkg::CMD_CHECK);
      upd.old_rank  = rank_ff;
      upd.seq       = seq_ff;
      upd.window    = win_ff;
      upd.status    = ack_ff;
      dup_in        = 1'b0;
      new_in        = 1'b0;
      ev_in         = 1'b0;
      if (cmd_ff == pprwd_pkg::CMD_STORE) begin
         upd.en        = (state_ff == ST_UPD) && hit_any_ff;
         upd.wr_status = 1'b1;
      end else if (!hit_any_ff) begin
         upd.fresh     = 1'b1;
         upd.wr_seq    = 1'b1;
         upd.window    = pprwd_pkg::win_type'(1);
         upd.wr_status = 1'b1;
         upd.status    = pprwd_pkg::STATUS_OK;
         new_in        = 1'b1;
         ev_in         = evict_ff;
      end else if (fwd_gap == 16'd0) begin
         dup_in = 1'b1;
      end else if (!fwd_gap[15]) begin
         // Forward slide; a shift of the window width or more clears it.
         upd.wr_seq = 1'b1;
         upd.window = pprwd_pkg::win_type'(win_ff << fwd_gap) | pprwd_pkg::win_type'(1);
      end else if (back >= 16'(pprwd_pkg::WINDOW_BITS)) begin
         // Far behind, including a distance of -32768: resync.
         upd.wr_seq = 1'b1;
         upd.window = pprwd_pkg::win_type'(1);
      end else begin
         dup_in     = |(win_ff & back_bit);
         upd.window = win_ff | back_bit;
      end
      cached_in    = dup_in ? status_ff : '0;
      rsp_valid_in = (state_ff == ST_UPD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPD) begin
         dup_ff    <= dup_in;
         cached_ff <= cached_in;
         new_ff    <= new_in;
         ev_ff     <= ev_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_duplicate  = dup_ff;
   assign rsp_cached_status = cached_ff;
   assign rsp_new_peer      = new_ff;
   assign rsp_evicted       = ev_ff;

   `PPRWD_ASSERT(a_hit_unique, $onehot0(hit_vec), "more than one cell matches the peer id")
   `PPRWD_ASSERT_IMP(a_victim_unique, !any_free, $onehot(victim_vec),
      "full table without one oldest peer")
   `PPRWD_ASSERT_IMP(a_target_onehot,
      state_ff == ST_UPD && cmd_ff == pprwd_pkg::CMD_CHECK, $onehot(target_ff),
      "check update without one target cell")
   `PPRWD_ASSERT_NXT(a_rsp_after_upd, state_ff == ST_UPD, rsp_valid,
      "update cycle gave no result strobe")
   `PPRWD_ASSERT_NXT(a_busy_after_start, start && !busy, busy && !rsp_valid,
      "accepted word did not raise busy")

endmodule

`default_nettype wire
